>>> hw/rtl/declaration_keyword_tagger_assert.svh
// Assertion macros shared by the declaration keyword tagger.
`ifndef DECLARATION_KEYWORD_TAGGER_ASSERT_SVH
`define DECLARATION_KEYWORD_TAGGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dkt assertion failed");

// Next-cycle implication, checked out of reset.
`define DKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dkt assertion failed");

`endif

>>> hw/rtl/dkt_pkg.sv
// Package with the keyword tables, scanner phases and shared structs.
package dkt_pkg;

  localparam int NumWords  = 8;
  localparam int WordChars = 9;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_MATCH  = 3'd1,
    PH_GAP    = 3'd2,
    PH_NAME   = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_MODIFIER = 3'd7;
  localparam logic [7:0] CHAR_NEWLINE  = 8'd10;

  localparam logic [8*WordChars-1:0] WORD_TEXT [NumWords] = '{
    "var      ", "function ", "class    ", "enum     ",
    "public   ", "static   ", "interface", "typedef  "
  };
  localparam logic [3:0] WORD_LEN [NumWords] = '{
    4'd3, 4'd8, 4'd5, 4'd4, 4'd6, 4'd6, 4'd9, 4'd7
  };
  localparam logic [2:0] WORD_KIND [NumWords] = '{
    3'd3, 3'd0, 3'd1, 3'd2, KIND_MODIFIER, KIND_MODIFIER, 3'd4, 3'd5
  };

  typedef struct packed {
    logic [2:0] tag_kind;
    logic [7:0] name_char;
    logic       last_of_name;
  } dkt_res_t;

  typedef struct packed {
    phase_t phase;
    logic   held_valid;
  } dkt_scan_sts_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } dkt_buf_sts_t;

  function automatic logic [7:0] word_char(input logic [2:0] k, input logic [3:0] pos);
    logic [3:0] ofs;
    ofs = 4'(WordChars - 1) - pos;
    if (pos > 4'(WordChars - 1)) begin
      return 8'd0;
    end
    return WORD_TEXT[k][{ofs, 3'b000} +: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

endpackage

>>> hw/rtl/dkt_scanner.sv
// Line scanner: keyword matching, name capture and the one-character hold.
module dkt_scanner import dkt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          in_mode,
  input  logic [7:0]    in_char,
  input  logic [5:0]    kind_enable,
  output logic          push,
  output dkt_res_t      res,
  output dkt_scan_sts_t sts
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] cand_r, cand_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hv_r, hv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      cand_r  <= '1;
      pos_r   <= '0;
      kind_r  <= '0;
      held_r  <= '0;
      hv_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      held_r  <= held_nxt;
      hv_r    <= hv_nxt;
    end
  end

  always_comb begin
    logic       line_start;
    logic       blank;
    logic       ident;
    logic [7:0] first;
    logic [7:0] keep;
    logic       done;
    logic [2:0] done_idx;
    logic [2:0] done_kind;
    phase_nxt  = phase_r;
    cand_nxt   = cand_r;
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    held_nxt   = held_r;
    hv_nxt     = hv_r;
    push       = 1'b0;
    res        = '{tag_kind: kind_r, name_char: held_r, last_of_name: 1'b0};
    line_start = 1'b0;
    blank      = is_blank(in_char);
    ident      = is_ident(in_char);
    first      = '0;
    keep       = '0;
    done       = 1'b0;
    done_idx   = '0;
    for (int k = 0; k < NumWords; k++) begin
      first[k] = (word_char(3'(k), 4'd0) == in_char);
      if (cand_r[k]) begin
        if (pos_r < WORD_LEN[k]) begin
          keep[k] = (word_char(3'(k), pos_r) == in_char);
        end else if (pos_r == WORD_LEN[k] && blank) begin
          done     = 1'b1;
          done_idx = 3'(k);
        end
      end
    end
    done_kind = WORD_KIND[done_idx];
    if (acc) begin
      if (in_mode) begin
        push             = hv_r;
        res.last_of_name = 1'b1;
        line_start       = 1'b1;
      end else if (in_char == CHAR_NEWLINE) begin
        push             = (phase_r == PH_NAME) && hv_r;
        res.last_of_name = 1'b1;
        line_start       = 1'b1;
      end else begin
        case (phase_r)
          PH_LEAD: begin
            if (!blank) begin
              if (first != '0) begin
                cand_nxt  = first;
                pos_nxt   = 4'd1;
                phase_nxt = PH_MATCH;
              end else begin
                phase_nxt = PH_IGNORE;
              end
            end
          end
          PH_MATCH: begin
            if (done) begin
              if (done_kind == KIND_MODIFIER) begin
                line_start = 1'b1;
              end else begin
                kind_nxt  = done_kind;
                pos_nxt   = '0;
                phase_nxt = kind_enable[done_kind] ? PH_GAP : PH_IGNORE;
              end
            end else if (keep != '0) begin
              cand_nxt = keep;
              pos_nxt  = pos_r + 4'd1;
            end else begin
              phase_nxt = PH_IGNORE;
            end
          end
          PH_GAP: begin
            if (ident) begin
              held_nxt  = in_char;
              hv_nxt    = 1'b1;
              phase_nxt = PH_NAME;
            end else if (!blank) begin
              phase_nxt = PH_IGNORE;
            end
          end
          PH_NAME: begin
            push = hv_r;
            if (ident) begin
              held_nxt = in_char;
              hv_nxt   = 1'b1;
            end else begin
              res.last_of_name = 1'b1;
              held_nxt         = '0;
              hv_nxt           = 1'b0;
              phase_nxt        = PH_IGNORE;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (line_start) begin
      phase_nxt = PH_LEAD;
      cand_nxt  = '1;
      pos_nxt   = '0;
      held_nxt  = '0;
      hv_nxt    = 1'b0;
    end
  end

  assign sts = '{phase: phase_r, held_valid: hv_r};

endmodule

>>> hw/rtl/dkt_out_skid.sv
// Result register with a skid stage so the input side keeps moving.
module dkt_out_skid import dkt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  dkt_res_t     push_res,
  input  logic         out_ready,
  output logic         out_valid,
  output dkt_res_t     out_res,
  output logic         room,
  output dkt_buf_sts_t sts
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  dkt_res_t out_res_r, out_res_nxt;
  dkt_res_t skid_res_r, skid_res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = push;
        skid_res_nxt   = push_res;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign room      = !skid_valid_r;
  assign sts       = '{out_full: out_valid_r, skid_full: skid_valid_r};

endmodule

>>> hw/rtl/declaration_keyword_tagger.sv
// Each result is registered, in the result register or in the skid stage.
// Throughput: one item per cycle while in_ready is high; the scanner state updates at every accepted item.
// in_ready drops only while both the result register and the skid stage hold results.
// Reset (rst_n low, synchronous) clears the scanner to line start, empties both
// output stages and sets kind_enable to all kinds enabled.
module declaration_keyword_tagger import dkt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_tag_kind,
  output logic [7:0] out_name_char,
  output logic       out_last_of_name,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  `include "declaration_keyword_tagger_assert.svh"

  logic [5:0]    kind_enable_r;
  logic [5:0]    kind_enable_nxt;
  logic          acc;
  logic          push;
  dkt_res_t      scan_res;
  dkt_res_t      out_res;
  dkt_scan_sts_t scan_sts;
  dkt_buf_sts_t  buf_sts;

  assign cfg_ready       = 1'b1;
  assign kind_enable_nxt = (cfg_valid && cfg_ready) ? cfg_data : kind_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_enable_r <= 6'h3F;
    end else begin
      kind_enable_r <= kind_enable_nxt;
    end
  end

  assign acc = in_valid && in_ready;

  dkt_scanner u_scanner (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_mode     (in_mode),
    .in_char     (in_char_byte),
    .kind_enable (kind_enable_r),
    .push        (push),
    .res         (scan_res),
    .sts         (scan_sts)
  );

  dkt_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (scan_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .room      (in_ready),
    .sts       (buf_sts)
  );

  assign out_tag_kind     = out_res.tag_kind;
  assign out_name_char    = out_res.name_char;
  assign out_last_of_name = out_res.last_of_name;

  `DKT_ASSERT_NOW(a_skid_behind_out, buf_sts.skid_full, buf_sts.out_full)
  `DKT_ASSERT_NOW(a_name_has_held, scan_sts.phase == PH_NAME, scan_sts.held_valid)
  `DKT_ASSERT_NEXT(a_flush_to_lead, acc && in_mode,
                   scan_sts.phase == PH_LEAD && !scan_sts.held_valid)
  `DKT_ASSERT_NOW(a_push_has_room, push, in_ready)

endmodule
